### sv/tsdc_pkg.sv
// Shared types and constants for the two-sensor direction counter.
`default_nettype none

package tsdc_pkg;

    localparam int unsigned COUNT_WIDTH_DEF = 32;
    localparam int unsigned TOTAL_WIDTH     = 32;
    localparam int unsigned PADDR_WIDTH     = 3;
    localparam int unsigned PDATA_WIDTH     = 32;
    localparam int unsigned S_TDATA_WIDTH   = 8;
    localparam int unsigned M_TDATA_WIDTH   = 104;

    // Register index, taken from paddr[2]
    typedef enum logic
    {
        REG_COUNTER_MODE     = 1'b0,
        REG_MANUAL_DIRECTION = 1'b1
    } reg_index_t;

    typedef enum logic [1:0]
    {
        EV_NONE = 2'd0,
        EV_FWD  = 2'd1,
        EV_REV  = 2'd2,
        EV_RSVD = 2'd3
    } count_event_t;

    typedef enum logic [1:0]
    {
        AU_IDLE       = 2'd0,
        AU_FIRST_LED  = 2'd1,
        AU_SECOND_LED = 2'd2,
        AU_COUNTED    = 2'd3
    } auto_phase_t;

    typedef enum logic [1:0]
    {
        MA_IDLE        = 2'd0,
        MA_WAIT_FIRST  = 2'd1,
        MA_WAIT_SECOND = 2'd2,
        MA_WRONG       = 2'd3
    } manual_phase_t;

    typedef struct packed
    {
        logic counter_mode;
        logic manual_direction;
        logic clear_phases;
    } cfg_t;

endpackage : tsdc_pkg

`default_nettype wire

### sv/tsdc_cfg.sv
// Configuration registers behind the APB port.
`default_nettype none

module tsdc_cfg
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tsdc_pkg::PADDR_WIDTH-1:0]  paddr,
    input  wire logic [tsdc_pkg::PDATA_WIDTH-1:0]  pwdata,
    output logic      [tsdc_pkg::PDATA_WIDTH-1:0]  prdata,
    output logic                                   pready,
    output tsdc_pkg::cfg_t                         cfg
);
    import tsdc_pkg::*;

    logic       counter_mode_reg;
    logic       manual_direction_reg;
    logic       wr_en;
    reg_index_t wr_index;

    assign pready   = 1'b1;
    assign wr_en    = psel & penable & pwrite & pready;
    assign wr_index = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_mode_reg     <= 1'b0;
            manual_direction_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_COUNTER_MODE:     counter_mode_reg     <= pwdata[0];
                REG_MANUAL_DIRECTION: manual_direction_reg <= pwdata[0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (wr_index)
            REG_COUNTER_MODE:     prdata[0] = counter_mode_reg;
            REG_MANUAL_DIRECTION: prdata[0] = manual_direction_reg;
            default:              prdata    = '0;
        endcase
    end

    // A mode write sends both trackers back to idle
    assign cfg.counter_mode     = counter_mode_reg;
    assign cfg.manual_direction = manual_direction_reg;
    assign cfg.clear_phases     = wr_en && (wr_index == REG_COUNTER_MODE);

endmodule : tsdc_cfg

`default_nettype wire

### sv/tsdc_track.sv
// Automatic and manual order trackers that turn sensor edges into passages.
`default_nettype none

module tsdc_track
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire tsdc_pkg::cfg_t          cfg,
    input  wire logic                    step,
    input  wire logic                    edge_sensor,
    input  wire logic                    other_level,
    output tsdc_pkg::count_event_t       count_event
);
    import tsdc_pkg::*;

    auto_phase_t   auto_phase_reg;
    auto_phase_t   auto_phase_next;
    manual_phase_t manual_phase_reg;
    manual_phase_t manual_phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_phase_reg   <= AU_IDLE;
            manual_phase_reg <= MA_IDLE;
        end
        else if (cfg.clear_phases)
        begin
            auto_phase_reg   <= AU_IDLE;
            manual_phase_reg <= MA_IDLE;
        end
        else if (step)
        begin
            auto_phase_reg   <= auto_phase_next;
            manual_phase_reg <= manual_phase_next;
        end
    end

    always_comb
    begin
        auto_phase_t   mine;
        auto_phase_t   theirs;
        logic          opener;
        manual_phase_t wait_phase;
        count_event_t  dir_event;

        auto_phase_next   = auto_phase_reg;
        manual_phase_next = manual_phase_reg;
        count_event       = EV_NONE;

        mine       = edge_sensor ? AU_SECOND_LED : AU_FIRST_LED;
        theirs     = edge_sensor ? AU_FIRST_LED : AU_SECOND_LED;
        // forward: second sensor opens and first completes; reverse mirrors it
        opener     = ~cfg.manual_direction;
        wait_phase = cfg.manual_direction ? MA_WAIT_SECOND : MA_WAIT_FIRST;
        dir_event  = cfg.manual_direction ? EV_REV : EV_FWD;

        if (!cfg.counter_mode)
        begin
            priority if (auto_phase_reg == mine)
            begin
                auto_phase_next = AU_IDLE;
            end
            else if (auto_phase_reg == AU_IDLE)
            begin
                if (other_level)
                    auto_phase_next = mine;
            end
            else if (auto_phase_reg == theirs && !other_level)
            begin
                auto_phase_next = AU_IDLE;
                count_event     = edge_sensor ? EV_FWD : EV_REV;
            end
            else
            begin
                // other sensor still high: phase holds
            end
        end
        else
        begin
            priority if (manual_phase_reg == MA_IDLE)
            begin
                manual_phase_next = (edge_sensor == opener) ? wait_phase : MA_WRONG;
            end
            else if (manual_phase_reg == wait_phase)
            begin
                if (edge_sensor != opener)
                begin
                    manual_phase_next = MA_IDLE;
                    auto_phase_next   = AU_IDLE;
                    count_event       = dir_event;
                end
            end
            else
            begin
                // wrong edge, or a phase left over from the other direction
                manual_phase_next = MA_IDLE;
            end
        end
    end

endmodule : tsdc_track

`default_nettype wire

### sv/tsdc_count.sv
// Forward, reverse and common passage totals.
`default_nettype none

module tsdc_count
#(
    parameter int unsigned COUNT_WIDTH = tsdc_pkg::COUNT_WIDTH_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               step,
    input  wire tsdc_pkg::count_event_t             count_event,
    output logic [tsdc_pkg::TOTAL_WIDTH-1:0]        forward_total,
    output logic [tsdc_pkg::TOTAL_WIDTH-1:0]        reverse_total,
    output logic [tsdc_pkg::TOTAL_WIDTH-1:0]        grand_total
);
    import tsdc_pkg::*;

    logic [COUNT_WIDTH-1:0] forward_count_reg;
    logic [COUNT_WIDTH-1:0] reverse_count_reg;
    logic [COUNT_WIDTH-1:0] common_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forward_count_reg <= '0;
            reverse_count_reg <= '0;
            common_count_reg  <= '0;
        end
        else if (step)
        begin
            unique case (count_event)
                EV_FWD:
                begin
                    forward_count_reg <= forward_count_reg + COUNT_WIDTH'(1);
                    common_count_reg  <= common_count_reg + COUNT_WIDTH'(1);
                end
                EV_REV:
                begin
                    reverse_count_reg <= reverse_count_reg + COUNT_WIDTH'(1);
                    common_count_reg  <= common_count_reg + COUNT_WIDTH'(1);
                end
                default: ;
            endcase
        end
    end

    assign forward_total = TOTAL_WIDTH'(forward_count_reg);
    assign reverse_total = TOTAL_WIDTH'(reverse_count_reg);
    assign grand_total   = TOTAL_WIDTH'(common_count_reg);

endmodule : tsdc_count

`default_nettype wire

### sv/two_sensor_direction_counter.sv
// Two-sensor direction counter: top level with input and result registers.
`default_nettype none

// Takes one sensor falling-edge request per cycle on s_axis and returns one
// result per request on m_axis. A request is held in an input register, then
// the trackers and totals update in the same cycle as the result register is
// loaded, so throughput is one request per clock; the only stall source is
// m_axis_tready. Totals are COUNT_WIDTH bits and wrap; the result shows their
// low 32 bits (zero-extended if narrower). Writing counter_mode (address 0)
// returns both trackers to idle; manual_direction lives at address 4.
// Configure only while idle.
module two_sensor_direction_counter
#(
    parameter int unsigned COUNT_WIDTH = tsdc_pkg::COUNT_WIDTH_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [0] edge_sensor, [1] other_level, [7:2] zero
    input  wire logic [tsdc_pkg::S_TDATA_WIDTH-1:0]  s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [1:0] count_event, [33:2] forward_total, [65:34] reverse_total,
    // [97:66] grand_total, [103:98] zero
    output logic      [tsdc_pkg::M_TDATA_WIDTH-1:0]  m_axis_tdata,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [tsdc_pkg::PADDR_WIDTH-1:0]    paddr,
    input  wire logic [tsdc_pkg::PDATA_WIDTH-1:0]    pwdata,
    output logic      [tsdc_pkg::PDATA_WIDTH-1:0]    prdata,
    output logic                                     pready
);
    import tsdc_pkg::*;

    cfg_t                   cfg;
    logic                   in_valid_reg;
    logic                   in_sensor_reg;
    logic                   in_other_reg;
    logic                   out_valid_reg;
    count_event_t           out_event_reg;
    count_event_t           step_event;
    logic                   step;
    logic [TOTAL_WIDTH-1:0] forward_total;
    logic [TOTAL_WIDTH-1:0] reverse_total;
    logic [TOTAL_WIDTH-1:0] grand_total;

    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (step)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_sensor_reg <= s_axis_tdata[0];
            in_other_reg  <= s_axis_tdata[1];
        end
        if (step)
            out_event_reg <= step_event;
    end

    tsdc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tsdc_track u_track
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .step        (step),
        .edge_sensor (in_sensor_reg),
        .other_level (in_other_reg),
        .count_event (step_event)
    );

    // Totals are held in the counters themselves and only move on a step,
    // which is also when the result register loads.
    tsdc_count #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_count
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .count_event   (step_event),
        .forward_total (forward_total),
        .reverse_total (reverse_total),
        .grand_total   (grand_total)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_WIDTH'({grand_total, reverse_total, forward_total,
                                           out_event_reg});

endmodule : two_sensor_direction_counter

`default_nettype wire

### sv/tsdc_checker.sv
// Port-level checks for the two-sensor direction counter, with bind.
`default_nettype none

module tsdc_checker
#(
    parameter int unsigned COUNT_WIDTH = tsdc_pkg::COUNT_WIDTH_DEF
)
(
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_axis_tready,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [tsdc_pkg::M_TDATA_WIDTH-1:0] m_axis_tdata
);
    import tsdc_pkg::*;

    localparam int unsigned CheckBits = (COUNT_WIDTH < TOTAL_WIDTH) ? COUNT_WIDTH
                                                                    : TOTAL_WIDTH;
    localparam logic [TOTAL_WIDTH-1:0] CheckMask = TOTAL_WIDTH'((64'd1 << CheckBits) - 64'd1);

    logic [TOTAL_WIDTH-1:0] sum_gap;

    assign sum_gap = m_axis_tdata[97:66] - m_axis_tdata[65:34] - m_axis_tdata[33:2];

    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != EV_RSVD))
        else $error("reserved count_event code on output");

    a_total_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((sum_gap & CheckMask) == '0))
        else $error("grand_total differs from forward plus reverse");

    a_stall_only_downstream: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output back-pressure");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

endmodule : tsdc_checker

bind two_sensor_direction_counter tsdc_checker #(
    .COUNT_WIDTH (COUNT_WIDTH)
) u_tsdc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
